### rtl/core/pmrp_pkg.sv
`default_nettype none

package pmrp_pkg;

  // chip and grid geometry
  localparam int CHIP_WIDTH  = 256;
  localparam int GRID_SIDE   = 2 * CHIP_WIDTH;
  localparam int STORE_DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = $clog2(GRID_SIDE);

  // signed working coordinate: 9-bit position plus 10-bit size, with sign
  localparam int CRD_W = 12;
  localparam int SQ_W  = 2 * CRD_W;

  localparam int INDEX_W = 18;
  localparam logic [INDEX_W-1:0] INDEX_ERR = '1;

  // width for the chip-order arithmetic before the 18-bit mask
  localparam int IDX_RAW_W  = $clog2(4 * CHIP_WIDTH * CHIP_WIDTH) + 2;
  localparam int IDX_CALC_W = (IDX_RAW_W > CRD_W) ? IDX_RAW_W : CRD_W;

  typedef logic signed [CRD_W-1:0] crd_t;
  typedef logic [SQ_W-1:0]         sq_t;

  typedef enum logic [1:0] {
    CMD_FILL   = 2'd0,
    CMD_RECT   = 2'd1,
    CMD_CIRCLE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_PAINT,
    ST_LIM,
    ST_ROW_SQ,
    ST_ROW_CAP,
    ST_PIX_SQ,
    ST_PIX_CHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic              wdata;
  } ram_req_t;

  typedef struct packed {
    logic               load;
    logic               read_valid;
    logic               mask_bit;
    logic [INDEX_W-1:0] chip_index;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/pmrp_ram.sv
`default_nettype none

module pmrp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/pmrp_sq_unit.sv
`default_nettype none

// shared squarer, one registered product per cycle
module pmrp_sq_unit (
  input  wire logic          clk,
  input  wire pmrp_pkg::crd_t op,
  output pmrp_pkg::sq_t       sq
);

  logic signed [pmrp_pkg::SQ_W-1:0] prod;

  assign prod = op * op;

  always_ff @(posedge clk) begin
    sq <= pmrp_pkg::SQ_W'(prod);
  end

endmodule

`default_nettype wire

### rtl/core/pmrp_seq.sv
`default_nettype none

module pmrp_seq (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              command,
  input  wire logic [8:0]              pos_x,
  input  wire logic [8:0]              pos_y,
  input  wire logic [9:0]              size_x,
  input  wire logic [9:0]              size_y,
  input  wire logic [8:0]              radius,
  input  wire logic                    mask_value,
  input  wire pmrp_pkg::sq_t           sq,
  output pmrp_pkg::crd_t               sq_op,
  output pmrp_pkg::ram_req_t           ram_req,
  input  wire logic                    ram_rdata,
  input  wire logic                    out_free,
  output pmrp_pkg::result_t            result
);

  localparam pmrp_pkg::crd_t SIDE = pmrp_pkg::CRD_W'(pmrp_pkg::GRID_SIDE);
  localparam pmrp_pkg::crd_t LAST = pmrp_pkg::CRD_W'(pmrp_pkg::GRID_SIDE - 1);

  function automatic logic [pmrp_pkg::INDEX_W-1:0] chip_order(
    input pmrp_pkg::crd_t r,
    input pmrp_pkg::crd_t c
  );
    logic [pmrp_pkg::IDX_CALC_W-1:0] w;
    logic [pmrp_pkg::IDX_CALC_W-1:0] a;
    logic [pmrp_pkg::IDX_CALC_W-1:0] b;
    logic [pmrp_pkg::IDX_CALC_W-1:0] idx;
    logic                            rc;
    logic                            cc;
    w  = pmrp_pkg::IDX_CALC_W'(pmrp_pkg::CHIP_WIDTH);
    rc = (r >= pmrp_pkg::CRD_W'(pmrp_pkg::CHIP_WIDTH));
    cc = (c >= pmrp_pkg::CRD_W'(pmrp_pkg::CHIP_WIDTH));
    a  = pmrp_pkg::IDX_CALC_W'(rc ? r - pmrp_pkg::CRD_W'(pmrp_pkg::CHIP_WIDTH) : r);
    b  = pmrp_pkg::IDX_CALC_W'(cc ? c - pmrp_pkg::CRD_W'(pmrp_pkg::CHIP_WIDTH) : c);
    if (rc && cc) begin
      idx = a + (w - 1'b1 - b) * w;
    end else if (rc) begin
      idx = w * w + (w - 1'b1 - a) + b * w;
    end else if (!cc) begin
      idx = pmrp_pkg::IDX_CALC_W'(2) * w * w + (w - 1'b1 - a) + b * w;
    end else begin
      idx = pmrp_pkg::IDX_CALC_W'(3) * w * w + a + (w - 1'b1 - b) * w;
    end
    return pmrp_pkg::INDEX_W'(idx);
  endfunction

  pmrp_pkg::state_t state, state_next;
  pmrp_pkg::cmd_t   cmd_r;
  logic             v_r;
  logic             silent;
  logic [9:0]       sx_r;
  logic [9:0]       sy_r;
  pmrp_pkg::crd_t   rad_r;
  pmrp_pkg::crd_t   cx;
  pmrp_pkg::crd_t   cy;
  pmrp_pkg::crd_t   row;
  pmrp_pkg::crd_t   col;
  pmrp_pkg::crd_t   col_first;
  pmrp_pkg::crd_t   row_last;
  pmrp_pkg::crd_t   col_last;
  pmrp_pkg::sq_t    lim;
  pmrp_pkg::sq_t    dy2;

  // clipped bounds, inclusive
  pmrp_pkg::crd_t b_rf, b_rl, b_cf, b_cl;
  pmrp_pkg::crd_t r_end, c_end;
  logic           b_empty;

  logic col_end, row_end, in_grid, in_disc, accept;
  logic [pmrp_pkg::SQ_W:0] dist_sq;

  assign accept  = in_valid && (state == pmrp_pkg::ST_IDLE);
  assign col_end = (col == col_last);
  assign row_end = (row == row_last);
  assign in_grid = (row < SIDE) && (col < SIDE);
  assign dist_sq = {1'b0, sq} + {1'b0, dy2};
  assign in_disc = (dist_sq <= {1'b0, lim});

  always_comb begin
    b_rf    = '0;
    b_rl    = LAST;
    b_cf    = '0;
    b_cl    = LAST;
    b_empty = 1'b0;
    r_end   = '0;
    c_end   = '0;
    case (cmd_r)
      pmrp_pkg::CMD_RECT: begin
        r_end = cy + pmrp_pkg::crd_t'({1'b0, sy_r});
        c_end = cx + pmrp_pkg::crd_t'({1'b0, sx_r});
        if (r_end > SIDE) begin
          r_end = SIDE;
        end
        if (c_end > SIDE) begin
          c_end = SIDE;
        end
        b_rf    = cy;
        b_cf    = cx;
        b_rl    = r_end - 1'b1;
        b_cl    = c_end - 1'b1;
        b_empty = (r_end <= cy) || (c_end <= cx);
      end
      pmrp_pkg::CMD_CIRCLE: begin
        b_rf = cy - rad_r;
        b_rl = cy + rad_r;
        b_cf = cx - rad_r;
        b_cl = cx + rad_r;
        if (b_rf < 0) begin
          b_rf = '0;
        end
        if (b_cf < 0) begin
          b_cf = '0;
        end
        if (b_rl > LAST) begin
          b_rl = LAST;
        end
        if (b_cl > LAST) begin
          b_cl = LAST;
        end
        b_empty = (b_rf > b_rl) || (b_cf > b_cl);
      end
      default: begin
        b_empty = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pmrp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = pmrp_pkg::ST_SETUP;
        end
      end
      pmrp_pkg::ST_SETUP: begin
        case (cmd_r)
          pmrp_pkg::CMD_READ:   state_next = pmrp_pkg::ST_DONE;
          pmrp_pkg::CMD_CIRCLE: state_next = b_empty ? pmrp_pkg::ST_DONE : pmrp_pkg::ST_LIM;
          default:              state_next = b_empty ? pmrp_pkg::ST_DONE : pmrp_pkg::ST_PAINT;
        endcase
      end
      pmrp_pkg::ST_PAINT: begin
        if (col_end && row_end) begin
          state_next = silent ? pmrp_pkg::ST_IDLE : pmrp_pkg::ST_DONE;
        end
      end
      pmrp_pkg::ST_LIM:     state_next = pmrp_pkg::ST_ROW_SQ;
      pmrp_pkg::ST_ROW_SQ:  state_next = pmrp_pkg::ST_ROW_CAP;
      pmrp_pkg::ST_ROW_CAP: state_next = pmrp_pkg::ST_PIX_CHK;
      pmrp_pkg::ST_PIX_SQ:  state_next = pmrp_pkg::ST_PIX_CHK;
      pmrp_pkg::ST_PIX_CHK: begin
        if (col_end && row_end) begin
          state_next = pmrp_pkg::ST_DONE;
        end else if (!col_end) begin
          state_next = pmrp_pkg::ST_PIX_SQ;
        end else begin
          state_next = pmrp_pkg::ST_ROW_SQ;
        end
      end
      pmrp_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = pmrp_pkg::ST_IDLE;
        end
      end
      default: state_next = pmrp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall      = (state != pmrp_pkg::ST_IDLE);
    sq_op         = '0;
    ram_req.we    = 1'b0;
    ram_req.re    = 1'b0;
    ram_req.wdata = v_r;
    ram_req.addr  = pmrp_pkg::ADDR_W'(row[pmrp_pkg::ROW_W-1:0])
                  * pmrp_pkg::ADDR_W'(pmrp_pkg::GRID_SIDE)
                  + pmrp_pkg::ADDR_W'(col[pmrp_pkg::ROW_W-1:0]);
    result.load       = 1'b0;
    result.read_valid = (cmd_r == pmrp_pkg::CMD_READ);
    result.mask_bit   = 1'b0;
    result.chip_index = '0;
    if (cmd_r == pmrp_pkg::CMD_READ) begin
      result.mask_bit   = in_grid & ram_rdata;
      result.chip_index = in_grid ? chip_order(row, col) : pmrp_pkg::INDEX_ERR;
    end
    case (state)
      pmrp_pkg::ST_SETUP: begin
        sq_op      = rad_r;
        ram_req.re = (cmd_r == pmrp_pkg::CMD_READ) && in_grid;
      end
      pmrp_pkg::ST_PAINT:   ram_req.we = 1'b1;
      pmrp_pkg::ST_ROW_SQ:  sq_op = row - cy;
      pmrp_pkg::ST_ROW_CAP: sq_op = col - cx;
      pmrp_pkg::ST_PIX_SQ:  sq_op = col - cx;
      pmrp_pkg::ST_PIX_CHK: ram_req.we = in_disc;
      pmrp_pkg::ST_DONE:    result.load = out_free;
      default:              sq_op = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= pmrp_pkg::ST_SETUP;
      cmd_r  <= pmrp_pkg::CMD_FILL;
      v_r    <= 1'b0;
      silent <= 1'b1;
    end else begin
      state <= state_next;
      if (accept) begin
        cmd_r  <= pmrp_pkg::cmd_t'(command);
        v_r    <= mask_value;
        silent <= 1'b0;
      end
      if (state == pmrp_pkg::ST_PAINT && col_end && row_end) begin
        silent <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      sx_r  <= size_x;
      sy_r  <= size_y;
      rad_r <= pmrp_pkg::crd_t'({1'b0, radius});
      cx    <= pmrp_pkg::crd_t'({1'b0, pos_x});
      cy    <= pmrp_pkg::crd_t'({1'b0, pos_y});
      row   <= pmrp_pkg::crd_t'({1'b0, pos_y});
      col   <= pmrp_pkg::crd_t'({1'b0, pos_x});
    end
    case (state)
      pmrp_pkg::ST_SETUP: begin
        if (cmd_r != pmrp_pkg::CMD_READ) begin
          row       <= b_rf;
          col       <= b_cf;
          col_first <= b_cf;
          row_last  <= b_rl;
          col_last  <= b_cl;
        end
      end
      pmrp_pkg::ST_LIM:     lim <= sq;
      pmrp_pkg::ST_ROW_CAP: dy2 <= sq;
      pmrp_pkg::ST_PAINT, pmrp_pkg::ST_PIX_CHK: begin
        if (!col_end) begin
          col <= col + 1'b1;
        end else if (!row_end) begin
          row <= row + 1'b1;
          col <= col_first;
        end
      end
      default: begin
        dy2 <= dy2;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/pixel_mask_region_painter.sv
`default_nettype none

// Pixel mask painter for a square detector of 2x2 chips (512 x 512 pixels
// at the default chip width): a one-bit store, 1 = masked, 0 = counting,
// held in a single-port RAM written or read at one pixel per cycle. Each
// request is one command and gives exactly one result; the block takes no
// new request while a command runs, but takes one while a result waits.
// Work per request: fill writes every pixel once; rectangle writes each pixel
// of the clipped rectangle once; circle visits each pixel of the clipped
// bounding box, squaring the row offset once per row and the column offset per
// pixel on the shared squarer, and writes where dx*dx + dy*dy is within
// radius*radius; read does one store access. After reset the block sweeps the
// store to zero, a setup step then one write per pixel, before its first request.
module pixel_mask_region_painter (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [8:0]  pos_x,
  input  wire logic [8:0]  pos_y,
  input  wire logic [9:0]  size_x,
  input  wire logic [9:0]  size_y,
  input  wire logic [8:0]  radius,
  input  wire logic        mask_value,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             read_valid,
  output logic             mask_bit,
  output logic [17:0]      chip_index
);

  pmrp_pkg::crd_t     sq_op;
  pmrp_pkg::sq_t      sq;
  pmrp_pkg::ram_req_t ram_req;
  pmrp_pkg::result_t  result;
  logic               ram_rdata;
  logic               out_free;

  // output register is free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;

  pmrp_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .size_x     (size_x),
    .size_y     (size_y),
    .radius     (radius),
    .mask_value (mask_value),
    .sq         (sq),
    .sq_op      (sq_op),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .out_free   (out_free),
    .result     (result)
  );

  // shared squarer: radius, row offset and column offset take turns
  pmrp_sq_unit u_sq (
    .clk (clk),
    .op  (sq_op),
    .sq  (sq)
  );

  // mask store, row-major
  pmrp_ram #(
    .WIDTH (1),
    .DEPTH (pmrp_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .re    (ram_req.re),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.load) begin
      read_valid <= result.read_valid;
      mask_bit   <= result.mask_bit;
      chip_index <= result.chip_index;
    end
  end

endmodule

`default_nettype wire
